### sv/eller_maze_row_generator_top_macros.svh
// assertion macros used by the top-level file
`ifndef ELLER_MAZE_ROW_GENERATOR_TOP_MACROS_SVH
`define ELLER_MAZE_ROW_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge out of reset
`define EMR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("emr assertion failed");
// consequent must hold in the cycle after the antecedent
`define EMR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("emr assertion failed");
`else
`define EMR_ASSERT(label, clk, rstn, prop)
`define EMR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

### sv/emr_pkg.sv
package emr_pkg;

    localparam int COLS      = 32;
    localparam int MAX_ROWS  = 1024;
    localparam int ROW_LIMIT = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;

    localparam int LBL_W     = $clog2(COLS);
    localparam int COL_W     = $clog2(COLS);
    localparam int CCFG_W    = 6;
    localparam int RCFG_W    = 11;
    localparam int ROW_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 11;

    localparam logic [CCFG_W-1:0] COLS_RESET = 6'd32;
    localparam logic [RCFG_W-1:0] ROWS_RESET = 11'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLS = 1'b0,
        REG_ROWS = 1'b1
    } emr_reg_t;

    typedef struct packed {
        logic [30:0] join_coins;
        logic [31:0] drop_coins;
    } emr_in_t;

    typedef struct packed {
        logic [9:0]  row_number;
        logic [30:0] vertical_walls;
        logic [31:0] floor_walls;
        logic        maze_done;
    } emr_out_t;

    typedef struct packed {
        logic load;
        logic join_step;
        logic open_step;
        logic relabel_step;
        logic emit;
        logic col_clr;
    } emr_cmd_t;

    typedef struct packed {
        logic last_row;
        logic one_col;
        logic last_join;
        logic last_col;
        logic out_busy;
    } emr_status_t;

endpackage

### sv/eller_maze_row_generator_top.sv
// Eller maze row generator: each input transfer carries one row's join and drop
// coins and yields one result transfer with the row's vertical walls, the floor
// walls below it, its row number and a last-row flag. A row is processed by
// column sweeps of a controller over a label datapath: an accept step, a sweep
// of set merging over each pair of neighbouring columns, a sweep of opening
// checks over every column in use, a sweep of fresh labeling over every column
// in use and a result write, which waits while an earlier result is still
// held and not taken. The last row skips openings and labeling, a one-column
// row skips merging. The result sits in an output register, so the next row is
// accepted while the previous result still waits. Configuration writes restart
// the maze and take effect with no clearing pass.
`include "eller_maze_row_generator_top_macros.svh"

module eller_maze_row_generator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // row coins
    input  logic                            s_valid,
    output logic                            s_ready,
    input  emr_pkg::emr_in_t                s_data,
    // row walls
    output logic                            m_valid,
    input  logic                            m_ready,
    output emr_pkg::emr_out_t               m_data,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [emr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [emr_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import emr_pkg::*;

    emr_cmd_t    cmd;
    emr_status_t status;
    logic        cfg_we;
    logic [4:0]  step_vec;

    // configuration is only written while idle, a rule for the user that the block does not enforce, so always take it
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // sequencer: walks the column sweeps of one row
    emr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // label store, wall registers, config and result register
    emr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    // at most one datapath operation per cycle
    assign step_vec = {cmd.load, cmd.join_step, cmd.open_step, cmd.relabel_step, cmd.emit};

    // an accepted row keeps the input side closed for the next cycle
    `EMR_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a result is never written over one that is still waiting
    `EMR_ASSERT(a_no_overwrite, aclk, aresetn, !cmd.emit || !status.out_busy)
    // writing the result presents it on the next cycle
    `EMR_ASSERT_NEXT(a_emit_shows, aclk, aresetn, cmd.emit, m_valid)
    // datapath commands never collide
    `EMR_ASSERT(a_one_step, aclk, aresetn, $onehot0(step_vec))

endmodule

### sv/emr_ctrl.sv
module emr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  emr_pkg::emr_status_t status,
    output emr_pkg::emr_cmd_t    cmd
);
    import emr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_JOIN,
        ST_OPEN,
        ST_RELABEL,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load    = 1'b1;
                    cmd.col_clr = 1'b1;
                    if (!status.one_col) begin
                        state_next = ST_JOIN;
                    end else if (status.last_row) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_OPEN;
                    end
                end
            end
            ST_JOIN: begin
                cmd.join_step = 1'b1;
                if (status.last_join) begin
                    cmd.col_clr = 1'b1;
                    state_next  = status.last_row ? ST_EMIT : ST_OPEN;
                end
            end
            ST_OPEN: begin
                cmd.open_step = 1'b1;
                if (status.last_col) begin
                    cmd.col_clr = 1'b1;
                    state_next  = ST_RELABEL;
                end
            end
            ST_RELABEL: begin
                cmd.relabel_step = 1'b1;
                if (status.last_col) begin
                    cmd.col_clr = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/emr_datapath.sv
module emr_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  emr_pkg::emr_in_t                    s_data,
    input  logic                                cfg_we,
    input  logic [emr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [emr_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  emr_pkg::emr_cmd_t                   cmd,
    output emr_pkg::emr_status_t                status,
    input  logic                                m_ready,
    output logic                                m_valid,
    output emr_pkg::emr_out_t                   m_data
);
    import emr_pkg::*;

    logic [CCFG_W-1:0] cols_reg;
    logic [RCFG_W-1:0] rows_reg;
    logic [LBL_W-1:0]  label_reg [COLS];
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [LBL_W-1:0]  left_reg;
    logic [30:0]       joins_reg;
    logic [30:0]       vwall_reg;
    logic [31:0]       floor_reg;
    emr_out_t          out_reg;
    logic              out_valid_reg;

    logic [CCFG_W-1:0] act_cols;
    logic [RCFG_W-1:0] act_rows;
    logic [31:0]       col_mask;
    logic              last_row;
    logic              cfg_restart;
    logic              restart;
    logic [COL_W-1:0]  rd_addr;
    logic [LBL_W-1:0]  rd_label;
    logic              merge;
    logic [31:0]       eq_vec;
    logic [31:0]       below_vec;
    logic              leftmost;
    logic              has_open;
    logic [31:0]       used_vec;
    logic [31:0]       free_vec;
    logic [31:0]       lowest_free;
    logic [LBL_W-1:0]  fresh_label;

    // clamp configuration into the supported range
    always_comb begin
        if (cols_reg == '0) begin
            act_cols = CCFG_W'(1);
        end else if (cols_reg > CCFG_W'(COLS)) begin
            act_cols = CCFG_W'(COLS);
        end else begin
            act_cols = cols_reg;
        end
        if (rows_reg == '0) begin
            act_rows = RCFG_W'(1);
        end else if (rows_reg > RCFG_W'(ROW_LIMIT)) begin
            act_rows = RCFG_W'(ROW_LIMIT);
        end else begin
            act_rows = rows_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < 32; k++) begin
            col_mask[k]  = (CCFG_W'(k) < act_cols);
            below_vec[k] = (COL_W'(k) < col_reg) && (k < COLS);
        end
    end

    assign last_row    = ((RCFG_W'(row_reg) + RCFG_W'(1)) >= act_rows);
    assign cfg_restart = cfg_we && (cfg_index == REG_COLS || cfg_index == REG_ROWS);
    assign restart     = cfg_restart || (cmd.emit && last_row);

    // single read port: right neighbor while joining, current column otherwise
    assign rd_addr  = cmd.join_step ? COL_W'(col_reg + 1'b1) : col_reg;
    assign rd_label = label_reg[rd_addr];
    assign merge    = (last_row || joins_reg[col_reg]) && (rd_label != left_reg);

    // set membership of the addressed column, broadcast over all active columns
    always_comb begin
        eq_vec = '0;
        for (int k = 0; k < COLS; k++) begin
            eq_vec[k] = col_mask[k] && (label_reg[k] == rd_label);
        end
    end

    assign leftmost = ~|(eq_vec & below_vec);
    assign has_open = |(eq_vec & ~floor_reg & ~below_vec);

    // lowest label not held by any other active column
    always_comb begin
        used_vec = '0;
        for (int k = 0; k < COLS; k++) begin
            if (col_mask[k] && (COL_W'(k) != col_reg)) begin
                used_vec[label_reg[k]] = 1'b1;
            end
        end
    end

    assign free_vec    = ~used_vec;
    assign lowest_free = free_vec & (~free_vec + 32'd1);

    always_comb begin
        fresh_label = '0;
        for (int k = 0; k < COLS; k++) begin
            if (lowest_free[k]) begin
                fresh_label = fresh_label | LBL_W'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_COLS: cols_reg <= cfg_data[CCFG_W-1:0];
                REG_ROWS: rows_reg <= cfg_data[RCFG_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            for (int k = 0; k < COLS; k++) begin
                label_reg[k] <= LBL_W'(k);
            end
        end else if (cmd.join_step && merge) begin
            for (int k = 0; k < COLS; k++) begin
                if (eq_vec[k]) begin
                    label_reg[k] <= left_reg;
                end
            end
        end else if (cmd.relabel_step && floor_reg[col_reg]) begin
            label_reg[col_reg] <= fresh_label;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_restart) begin
            row_reg <= '0;
        end else if (cmd.emit) begin
            row_reg <= last_row ? '0 : ROW_W'(row_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (cmd.col_clr) begin
            col_reg <= '0;
        end else if (cmd.join_step || cmd.open_step || cmd.relabel_step) begin
            col_reg <= COL_W'(col_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            left_reg  <= label_reg[0];
            joins_reg <= s_data.join_coins;
            vwall_reg <= '1;
            floor_reg <= last_row ? '1 : ~(s_data.drop_coins & col_mask);
        end else begin
            if (cmd.join_step) begin
                left_reg <= merge ? left_reg : rd_label;
                if (merge) begin
                    vwall_reg[col_reg] <= 1'b0;
                end
            end
            if (cmd.open_step && leftmost && !has_open) begin
                floor_reg[col_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.row_number     <= row_reg;
            out_reg.vertical_walls <= vwall_reg;
            out_reg.floor_walls    <= floor_reg;
            out_reg.maze_done      <= last_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign status.last_row  = last_row;
    assign status.one_col   = (act_cols == CCFG_W'(1));
    assign status.last_join = ((CCFG_W'(col_reg) + CCFG_W'(2)) == act_cols);
    assign status.last_col  = ((CCFG_W'(col_reg) + CCFG_W'(1)) == act_cols);
    assign status.out_busy  = out_valid_reg && !m_ready;

endmodule

### sim/tb.sv
module tb;
    import emr_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 120;
    localparam int RANDOM_ROWS = 440;
    localparam int WRAP_ROWS   = 300;
    localparam int MAX_PRINTS  = 100;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    emr_in_t              s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    emr_out_t             m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_COLS;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // own copy of the maze state
    logic [4:0]        set_label [32];
    logic [9:0]        row_idx;
    logic [CCFG_W-1:0] cols_reg;
    logic [RCFG_W-1:0] rows_reg;

    emr_out_t expected_walls[$];

    int errors         = 0;
    int rows_sent      = 0;
    int mazes_finished = 0;
    int reg_writes     = 0;
    int send_gap_pct   = 30;
    int sink_stall_pct = 30;
    int quiet_cycles   = 0;

    eller_maze_row_generator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic report_error(string msg);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // ---------------------------------------------------------------
    // maze predictor
    // ---------------------------------------------------------------

    function automatic void restart_labels();
        for (int j = 0; j < 32; j++) begin
            set_label[j] = j[4:0];
        end
        row_idx = '0;
    endfunction

    function automatic emr_out_t predict_row(emr_in_t coins);
        int          ncols;
        int          nrows;
        int          lab;
        logic        last;
        logic        lead;
        logic        opened;
        logic [30:0] vwalls;
        logic [31:0] fwalls;
        logic [31:0] used;
        logic [4:0]  merged;
        emr_out_t    res;
        ncols = int'(cols_reg);
        if (ncols < 1) ncols = 1;
        if (ncols > COLS) ncols = COLS;
        nrows = int'(rows_reg);
        if (nrows < 1) nrows = 1;
        if (nrows > ROW_LIMIT) nrows = ROW_LIMIT;
        last   = (int'(row_idx) + 1 >= nrows);
        vwalls = '1;
        fwalls = '1;

        // merge sweep, right set folds into the left one
        for (int j = 0; j + 1 < ncols; j++) begin
            if ((last || coins.join_coins[j]) && set_label[j] != set_label[j+1]) begin
                merged    = set_label[j+1];
                vwalls[j] = 1'b0;
                for (int k = 0; k < ncols; k++) begin
                    if (set_label[k] == merged) set_label[k] = set_label[j];
                end
            end
        end

        if (!last) begin
            for (int j = 0; j < ncols; j++) begin
                if (coins.drop_coins[j]) fwalls[j] = 1'b0;
            end
            // a set with no opening gets one at its leftmost cell
            for (int j = 0; j < ncols; j++) begin
                lead = 1'b1;
                for (int k = 0; k < j; k++) begin
                    if (set_label[k] == set_label[j]) lead = 1'b0;
                end
                if (lead) begin
                    opened = 1'b0;
                    for (int k = j; k < ncols; k++) begin
                        if (set_label[k] == set_label[j] && !fwalls[k]) opened = 1'b1;
                    end
                    if (!opened) fwalls[j] = 1'b0;
                end
            end
        end

        res.row_number     = row_idx;
        res.vertical_walls = vwalls;
        res.floor_walls    = fwalls;
        res.maze_done      = last;

        if (last) begin
            restart_labels();
        end else begin
            // closed cells start a set of their own
            for (int j = 0; j < ncols; j++) begin
                if (fwalls[j]) begin
                    used = '0;
                    for (int k = 0; k < ncols; k++) begin
                        if (k != j) used[set_label[k]] = 1'b1;
                    end
                    lab = 0;
                    while (lab < 32 && used[lab]) lab++;
                    if (lab < 32) set_label[j] = lab[4:0];
                end
            end
            row_idx = row_idx + 10'd1;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // drivers, all called and returning at a falling edge
    // ---------------------------------------------------------------

    task automatic send_row(logic [30:0] joins, logic [31:0] drops);
        emr_in_t coins;
        coins.join_coins = joins;
        coins.drop_coins = drops;
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= coins;
        do @(posedge aclk); while (!s_ready);
        expected_walls.push_back(predict_row(coins));
        rows_sent++;
        @(negedge aclk);
    endtask

    // sender holds off until every pending row has come back
    task automatic hold_off();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_walls.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(emr_reg_t idx, logic [CFG_DAT_W-1:0] val);
        hold_off();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_COLS) cols_reg = val[CCFG_W-1:0];
        else                 rows_reg = val[RCFG_W-1:0];
        restart_labels();
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] coin_word();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom() & $urandom();
            3:       return $urandom() | $urandom();
            default: return $urandom();
        endcase
    endfunction

    // ---------------------------------------------------------------
    // sink and result checking
    // ---------------------------------------------------------------

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        emr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_walls.size() == 0) begin
                report_error($sformatf("unexpected result transfer row %0d",
                                       m_data.row_number));
            end else begin
                want = expected_walls.pop_front();
                if (m_data.row_number !== want.row_number)
                    report_error($sformatf("row_number got %0d want %0d",
                                           m_data.row_number, want.row_number));
                if (m_data.vertical_walls !== want.vertical_walls)
                    report_error($sformatf("row %0d vertical_walls got %h want %h",
                                           want.row_number, m_data.vertical_walls,
                                           want.vertical_walls));
                if (m_data.floor_walls !== want.floor_walls)
                    report_error($sformatf("row %0d floor_walls got %h want %h",
                                           want.row_number, m_data.floor_walls,
                                           want.floor_walls));
                if (m_data.maze_done !== want.maze_done)
                    report_error($sformatf("row %0d maze_done got %b want %b",
                                           want.row_number, m_data.maze_done,
                                           want.maze_done));
                if (want.maze_done) mazes_finished++;
            end
        end
    end

    // no transfer on any channel for too long means the block hung
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d rows pending",
                     quiet_cycles, expected_walls.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // default 32 by 32 maze straight out of reset
    task automatic test_default_rows();
        send_row('0, '0);
        send_row('1, '0);
        send_row('0, '1);
        send_row(31'h5555_5555, 32'hAAAA_AAAA);
        send_row(31'h2AAA_AAAA, 32'h5555_5555);
        send_row(31'h4000_0000, 32'h8000_0000);
        send_row(31'h0000_0001, 32'h0000_0001);
        send_row(31'(coin_word()), coin_word());
    endtask

    // zero, one and two columns, and counts past the column limit
    task automatic test_column_limits();
        write_reg(REG_ROWS, 11'd2);
        write_reg(REG_COLS, 11'd0);
        send_row('1, '1);
        send_row('0, '0);
        write_reg(REG_COLS, 11'd1);
        send_row('0, '0);
        send_row('1, '1);
        write_reg(REG_COLS, 11'd2);
        send_row('1, '0);
        send_row(31'h7FFF_FFFE, 32'hFFFF_FFFC);
        // upper data bits dropped, then 34 clamps to the full width
        write_reg(REG_COLS, 11'h7E2);
        send_row(31'(coin_word()), coin_word());
        send_row(31'(coin_word()), coin_word());
    endtask

    // single row mazes and row counts past the row limit
    task automatic test_row_limits();
        write_reg(REG_COLS, 11'd4);
        write_reg(REG_ROWS, 11'd0);
        send_row('0, '0);
        send_row(31'h0000_0005, 32'h0000_000F);
        write_reg(REG_ROWS, 11'd1);
        send_row('0, '1);
        write_reg(REG_ROWS, 11'h7FF);
        send_row('0, '0);
        send_row('1, '0);
        write_reg(REG_ROWS, 11'd1024);
        send_row(31'(coin_word()), coin_word());
    endtask

    task automatic test_random_mazes();
        logic [CFG_DAT_W-1:0] cols_val;
        logic [CFG_DAT_W-1:0] rows_val;
        int span;
        int count;
        int phase;
        int done_rows;
        phase     = 0;
        done_rows = 0;
        while (done_rows < RANDOM_ROWS) begin
            case ($urandom_range(9))
                0:       cols_val = 11'd0;
                1:       cols_val = 11'd1;
                2:       cols_val = 11'd32;
                3:       cols_val = CFG_DAT_W'($urandom_range(33, 63));
                4:       cols_val = CFG_DAT_W'($urandom_range(0, 2047));
                default: cols_val = CFG_DAT_W'($urandom_range(2, 31));
            endcase
            case ($urandom_range(9))
                0:       rows_val = 11'd0;
                1:       rows_val = 11'd1;
                2:       rows_val = CFG_DAT_W'($urandom_range(1025, 2047));
                default: rows_val = CFG_DAT_W'($urandom_range(2, 24));
            endcase
            span = (rows_val == 0) ? 1 :
                   (int'(rows_val) > ROW_LIMIT) ? ROW_LIMIT : int'(rows_val);
            count = span * $urandom_range(1, 3) + $urandom_range(0, span);
            if (count > 120) count = $urandom_range(40, 120);

            // one phase runs flat out on both sides
            if (phase == 2) begin
                send_gap_pct   = 0;
                sink_stall_pct = 0;
            end else begin
                send_gap_pct   = 30;
                sink_stall_pct = 30;
            end

            if ($urandom_range(1)) begin
                write_reg(REG_COLS, cols_val);
                write_reg(REG_ROWS, rows_val);
            end else begin
                write_reg(REG_ROWS, rows_val);
                write_reg(REG_COLS, cols_val);
            end
            for (int n = 0; n < count; n++) begin
                if (phase == 4 && n == count / 2) hold_off();
                send_row(31'(coin_word()), coin_word());
            end
            done_rows += count;
            phase++;
        end
        send_gap_pct   = 30;
        sink_stall_pct = 30;
    endtask

    // a long single column maze, then the wrap into a new one
    task automatic test_row_counter_wrap();
        write_reg(REG_COLS, 11'd1);
        write_reg(REG_ROWS, CFG_DAT_W'(WRAP_ROWS));
        send_gap_pct   = 0;
        sink_stall_pct = 10;
        for (int n = 0; n < WRAP_ROWS + 2; n++) begin
            send_row(31'(coin_word()), coin_word());
        end
        send_gap_pct   = 30;
        sink_stall_pct = 30;
    endtask

    initial begin
        cols_reg = COLS_RESET;
        rows_reg = ROWS_RESET;
        restart_labels();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_default_rows();
        test_column_limits();
        test_row_limits();
        test_random_mazes();
        test_row_counter_wrap();

        s_valid <= 1'b0;
        while (expected_walls.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_walls.size() != 0)
            report_error($sformatf("%0d rows never came back", expected_walls.size()));

        $display("covered %0d rows, %0d completed mazes, %0d register writes",
                 rows_sent, mazes_finished, reg_writes);
        $display("column counts 0 to 63, row counts 0 to 2047, %0d mismatches", errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/emr_pkg.sv
sv/emr_ctrl.sv
sv/emr_datapath.sv
sv/eller_maze_row_generator_top.sv
sim/tb.sv
